// ----- src/tds_pkg.sv -----
`default_nettype none

package tds_pkg;

  // Input command codes
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SCHED  = 2'd1;
  localparam logic [1:0] CMD_DESCHED = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_FIRED   = 2'd0;
  localparam logic [1:0] ST_SCHEDULED = 2'd1;
  localparam logic [1:0] ST_DESCHEDULED = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  localparam int SLOTS_DEF = 16;
  localparam int CPM_W     = 20;
  localparam int DELAY_W   = 32;
  localparam int OFFSET_W  = DELAY_W + CPM_W;
  localparam int COUNT_W   = 64;
  localparam int HANDLE_W  = 4;

  localparam logic [CPM_W-1:0] CPM_RESET = CPM_W'(1000);

endpackage

`default_nettype wire

// ----- src/timer_deadline_scheduler_core.sv -----
`default_nettype none

// Deadline timer scheduler.
// Input channel (in_valid / in_stall) takes one command word: tick, schedule
// or deschedule. Result channel (out_valid / out_stall) returns the words it
// causes: one word for schedule, deschedule or an unknown command, one word
// per fired slot for a tick (none for a quiet tick), out_last on the final one.
// Every result word carries the earliest pending deadline after its action.
// cfg_we / cfg_wdata write counts_per_ms; the user must write it only while
// the block is idle: the block itself does not enforce this.
// Deadlines and periods sit in two SLOTS-deep memories with one read port
// each, so each command is worked by a scan pass over the table and then a
// decide step; a tick makes one pass plus one more per fired slot. One word
// is worked on at a time; in_stall is high while it is.
// Reset (synchronous, rst_n low) clears the count, all valid marks, the
// control state and the output valid flag, and sets counts_per_ms to 1000.
// The memories are not cleared: an entry's data is only used while its valid
// mark is set. No clearing pass.
// A stalled result word holds in the output register; the next command is
// still taken meanwhile, and the decide step waits while a word is stalled.
module timer_deadline_scheduler_core #(
  parameter int SLOTS = tds_pkg::SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [1:0]                    in_command,
  input  wire logic [tds_pkg::DELAY_W-1:0]   in_delay_ms,
  input  wire logic                          in_periodic,
  input  wire logic [tds_pkg::HANDLE_W-1:0]  in_target_slot,
  // result channel
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [1:0]                    out_status,
  output      logic [tds_pkg::HANDLE_W-1:0]  out_timer_slot,
  output      logic                          out_any_pending,
  output      logic [tds_pkg::COUNT_W-1:0]   out_next_deadline,
  output      logic                          out_last,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [tds_pkg::CPM_W-1:0]     cfg_wdata
);
  import tds_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  // Deadline and period store, one read and one write port each
  logic [COUNT_W-1:0] dl_mem  [SLOTS];
  logic [COUNT_W-1:0] per_mem [SLOTS];

  state_t               state_r, state_nxt;
  logic [1:0]           cmd_r, cmd_nxt;
  logic                 periodic_r, periodic_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [CPM_W-1:0]     cpm_r;
  logic [OFFSET_W-1:0]  offset_r, offset_nxt;
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic [SLOTS-1:0]     fired_r, fired_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [HANDLE_W-1:0]  res_slot_r, res_slot_nxt;

  // scan sequencer
  logic [SW-1:0]        rd_addr_r, rd_addr_nxt;
  logic                 rd_go_r, rd_go_nxt;
  logic                 dv_r;
  logic [SW-1:0]        idx_r;
  logic [COUNT_W-1:0]   dl_q_r, per_q_r;

  // scan accumulators
  logic                 min_any_r, min_any_nxt;
  logic [COUNT_W-1:0]   min_dl_r, min_dl_nxt;
  logic                 pick_found_r, pick_found_nxt;
  logic [SW-1:0]        pick_idx_r, pick_idx_nxt;
  logic [COUNT_W-1:0]   pick_dl_r, pick_dl_nxt;
  logic [COUNT_W-1:0]   pick_per_r, pick_per_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [SW-1:0]        free_idx_r, free_idx_nxt;

  // fired slot waiting for the next pass to give its next_deadline
  logic                 pend_r, pend_nxt;
  logic [SW-1:0]        pend_slot_r, pend_slot_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0]  out_slot_r, out_slot_nxt;
  logic                 out_any_r, out_any_nxt;
  logic [COUNT_W-1:0]   out_dl_r, out_dl_nxt;
  logic                 out_last_r, out_last_nxt;

  // memory write port
  logic                 wr_dl_en, wr_per_en;
  logic [SW-1:0]        wr_addr;
  logic [COUNT_W-1:0]   wr_dl, wr_per;

  logic                 in_acc;
  logic                 can_load;
  logic                 start_scan;
  logic                 tgt_ok;
  logic                 cur_valid;
  logic [COUNT_W-1:0]   new_dl;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign can_load = !out_valid_r || !out_stall;

  assign tgt_ok    = (int'(in_target_slot) < SLOTS) && valid_r[SW'(in_target_slot)];
  assign cur_valid = valid_r[idx_r];
  assign new_dl    = count_r + COUNT_W'(offset_r);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    periodic_nxt   = periodic_r;
    count_nxt      = count_r;
    offset_nxt     = offset_r;
    valid_nxt      = valid_r;
    fired_nxt      = fired_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    rd_addr_nxt    = rd_addr_r;
    rd_go_nxt      = rd_go_r;
    min_any_nxt    = min_any_r;
    min_dl_nxt     = min_dl_r;
    pick_found_nxt = pick_found_r;
    pick_idx_nxt   = pick_idx_r;
    pick_dl_nxt    = pick_dl_r;
    pick_per_nxt   = pick_per_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    pend_nxt       = pend_r;
    pend_slot_nxt  = pend_slot_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_any_nxt    = out_any_r;
    out_dl_nxt     = out_dl_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    wr_dl_en       = 1'b0;
    wr_per_en      = 1'b0;
    wr_addr        = pick_idx_r;
    wr_dl          = pick_dl_r + pick_per_r;
    wr_per         = '0;
    start_scan     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt      = in_command;
          periodic_nxt = in_periodic;
          offset_nxt   = OFFSET_W'(in_delay_ms) * OFFSET_W'(cpm_r);
          pend_nxt     = 1'b0;
          start_scan   = 1'b1;
          res_status_nxt = ST_REJECTED;
          res_slot_nxt   = '0;
          unique case (in_command)
            CMD_TICK: begin
              count_nxt = count_r + COUNT_W'(1);
              fired_nxt = '0;
            end
            CMD_SCHED: begin
            end
            CMD_DESCHED: begin
              res_slot_nxt = in_target_slot;
              if (tgt_ok) begin
                valid_nxt[SW'(in_target_slot)] = 1'b0;
                res_status_nxt = ST_DESCHEDULED;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_go_r) begin
          rd_go_nxt   = (rd_addr_r != LAST_IDX);
          rd_addr_nxt = SW'(rd_addr_r + 1'b1);
        end
        if (dv_r) begin
          if (cur_valid && (!min_any_r || dl_q_r < min_dl_r)) begin
            min_any_nxt = 1'b1;
            min_dl_nxt  = dl_q_r;
          end
          // earliest due slot not yet fired this tick; ties keep the lower slot
          if ((cmd_r == CMD_TICK) && cur_valid && !fired_r[idx_r] &&
              (dl_q_r <= count_r) && (!pick_found_r || dl_q_r < pick_dl_r)) begin
            pick_found_nxt = 1'b1;
            pick_idx_nxt   = idx_r;
            pick_dl_nxt    = dl_q_r;
            pick_per_nxt   = per_q_r;
          end
          if (!cur_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx_r;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        if (can_load) begin
          out_last_nxt = 1'b1;
          out_any_nxt  = min_any_r;
          out_dl_nxt   = min_any_r ? min_dl_r : '0;
          state_nxt    = S_IDLE;
          unique case (cmd_r)
            CMD_TICK: begin
              // word for the slot fired on the previous pass
              out_valid_nxt  = pend_r;
              out_status_nxt = ST_FIRED;
              out_slot_nxt   = HANDLE_W'(pend_slot_r);
              out_last_nxt   = !pick_found_r;
              if (pick_found_r) begin
                fired_nxt[pick_idx_r] = 1'b1;
                if (pick_per_r == '0) begin
                  valid_nxt[pick_idx_r] = 1'b0;
                end else begin
                  wr_dl_en = 1'b1;
                end
                pend_nxt      = 1'b1;
                pend_slot_nxt = pick_idx_r;
                start_scan    = 1'b1;
              end
            end
            CMD_SCHED: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_REJECTED;
              out_slot_nxt   = '0;
              if ((offset_r != '0) && free_found_r) begin
                wr_dl_en  = 1'b1;
                wr_per_en = 1'b1;
                wr_addr   = free_idx_r;
                wr_dl     = new_dl;
                wr_per    = periodic_r ? COUNT_W'(offset_r) : '0;
                valid_nxt[free_idx_r] = 1'b1;
                out_status_nxt = ST_SCHEDULED;
                out_slot_nxt   = HANDLE_W'(free_idx_r);
                out_any_nxt    = 1'b1;
                out_dl_nxt     = (min_any_r && min_dl_r < new_dl) ? min_dl_r : new_dl;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = res_status_r;
              out_slot_nxt   = res_slot_r;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (start_scan) begin
      state_nxt      = S_SCAN;
      rd_addr_nxt    = '0;
      rd_go_nxt      = 1'b1;
      min_any_nxt    = 1'b0;
      pick_found_nxt = 1'b0;
      free_found_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cpm_r       <= CPM_RESET;
      valid_r     <= '0;
      fired_r     <= '0;
      rd_go_r     <= 1'b0;
      dv_r        <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      if (cfg_we) begin
        cpm_r <= cfg_wdata;
      end
      valid_r     <= valid_nxt;
      fired_r     <= fired_nxt;
      rd_go_r     <= rd_go_nxt;
      dv_r        <= rd_go_r && (state_r == S_SCAN);
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan data
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    periodic_r   <= periodic_nxt;
    offset_r     <= offset_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    rd_addr_r    <= rd_addr_nxt;
    idx_r        <= rd_addr_r;
    min_any_r    <= min_any_nxt;
    min_dl_r     <= min_dl_nxt;
    pick_found_r <= pick_found_nxt;
    pick_idx_r   <= pick_idx_nxt;
    pick_dl_r    <= pick_dl_nxt;
    pick_per_r   <= pick_per_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    pend_slot_r  <= pend_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_any_r    <= out_any_nxt;
    out_dl_r     <= out_dl_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Memories. Writes happen only in S_DECIDE and reads are only used in
  // S_SCAN, so a read never meets a write to the same entry.
  always_ff @(posedge clk) begin
    if (wr_dl_en) begin
      dl_mem[wr_addr] <= wr_dl;
    end
    if (wr_per_en) begin
      per_mem[wr_addr] <= wr_per;
    end
    dl_q_r  <= dl_mem[rd_addr_r];
    per_q_r <= per_mem[rd_addr_r];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_timer_slot    = out_slot_r;
  assign out_any_pending   = out_any_r;
  assign out_next_deadline = out_dl_r;
  assign out_last          = out_last_r;

  // Memory writes only from the decide step
  a_wr_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_dl_en || wr_per_en) |-> (state_r == S_DECIDE))
    else $error("memory write outside decide step");

  // A slot chosen to fire must be due
  a_pick_due: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && cmd_r == CMD_TICK && pick_found_r) |-> (pick_dl_r <= count_r))
    else $error("fired slot not yet due");

  // Each tick starts with no slot marked fired
  a_fired_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_command == CMD_TICK) |=> (fired_r == '0))
    else $error("fired marks not cleared on tick");

  // No pending timer means a zero compare value
  a_idle_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_any_r) |-> (out_dl_r == '0))
    else $error("deadline reported with nothing pending");

endmodule

`default_nettype wire
